// ----- rtl/core/sfcc_pkg.sv -----
`default_nettype none
package sfcc_pkg;

	localparam logic [7:0]  CRC_INIT       = 8'hFF;
	localparam logic [7:0]  CRC_POLY_RESET = 8'h31;
	localparam logic        CRC_EN_RESET   = 1'b1;

	localparam int          TEMP_PROD_W = 29;
	localparam int          HUM_PROD_W  = 26;
	localparam int          TEMP_SHIFT  = 14;
	localparam int          HUM_SHIFT   = 12;
	localparam logic [12:0] TEMP_GAIN   = 13'd4375;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [9:0]  HUM_GAIN    = 10'd625;

	typedef enum logic [2:0] {
		POS_T_MSB,
		POS_T_LSB,
		POS_T_CRC,
		POS_H_MSB,
		POS_H_LSB,
		POS_H_CRC
	} byte_pos_t;

	typedef enum logic [0:0] {
		CFG_CRC_ENABLE,
		CFG_CRC_POLY
	} cfg_reg_t;

	typedef logic signed [14:0] temp_t;
	typedef logic [13:0]        hum_t;

	// msb-first crc-8, one byte, eight shift steps
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sfcc_if.sv -----
`default_nettype none
interface sfcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcc_result_if;
	logic                 valid;
	logic                 ready;
	sfcc_pkg::temp_t      temperature_centideg;
	sfcc_pkg::hum_t       humidity_centipct;
	logic                 checksum_error;

	modport source (output valid, output temperature_centideg, output humidity_centipct,
		output checksum_error, input ready);
	modport sink (input valid, input temperature_centideg, input humidity_centipct,
		input checksum_error, output ready);
endinterface

interface sfcc_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sensor_frame_crc_and_conversion_top.sv -----
// sensor frame checker and converter
//
// frame_bytes takes one sensor byte per item: temperature msb, lsb, crc, then
// humidity msb, lsb, crc. frame_start on an item makes it byte 0 of a new frame
// and drops any partial frame. each word is checked with an msb-first crc-8,
// init 0xff, polynomial from the cfg register.
// readings carries one item per frame, formed on the sixth byte: temperature
// in hundredths of a degree, humidity in hundredths of a percent, and a flag
// set when a checksum mismatched while checking is enabled.
// cfg writes register 0 (check enable, data bit 0) or 1 (polynomial); it is
// always ready and must only be used while no byte is in flight.
// the sixth byte passes through the input register and then the reading
// register. one byte is accepted every cycle unless a byte waits as below;
// the input register and the reading register keep bytes flowing while a reading waits.
// when readings stalls, a byte that would form a new reading waits in the input
// register; other bytes keep passing.
// reset clears frame position, crc, valid flags and restores the registers to
// check enabled, polynomial 0x31.
`default_nettype none
module sensor_frame_crc_and_conversion_top (
	input wire logic      clk,
	input wire logic      arst_n,
	sfcc_byte_if.sink     frame_bytes,
	sfcc_result_if.source readings,
	sfcc_cfg_if.sink      cfg
);

	logic                 crc_en_q;
	logic [7:0]           crc_poly_q;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;

	sfcc_pkg::byte_pos_t  pos_q;
	sfcc_pkg::byte_pos_t  pos_eff;
	sfcc_pkg::byte_pos_t  pos_next;
	logic [7:0]           crc_q;
	logic [7:0]           crc_in;
	logic [7:0]           crc_step;
	logic [7:0]           crc_next;
	logic [15:0]          temp_word_q;
	logic [15:0]          temp_word_next;
	logic                 temp_bad_q;
	logic                 temp_bad_next;
	logic [7:0]           hum_hi_q;
	logic [7:0]           hum_hi_next;
	logic [7:0]           hum_lo_q;
	logic [7:0]           hum_lo_next;

	logic                 restart;
	logic                 final_byte;
	logic                 advance;
	logic                 err_now;

	logic                 out_valid_q;
	sfcc_pkg::temp_t      temp_res_q;
	sfcc_pkg::hum_t       hum_res_q;
	logic                 err_res_q;
	sfcc_pkg::temp_t      temp_conv;
	sfcc_pkg::hum_t       hum_conv;

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_en_q   <= sfcc_pkg::CRC_EN_RESET;
			crc_poly_q <= sfcc_pkg::CRC_POLY_RESET;
		end else if (cfg.valid) begin
			unique case (sfcc_pkg::cfg_reg_t'(cfg.index))
				sfcc_pkg::CFG_CRC_ENABLE: crc_en_q   <= cfg.data[0];
				sfcc_pkg::CFG_CRC_POLY:   crc_poly_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	assign frame_bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_bytes.ready) begin
			valid_s1 <= frame_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_bytes.valid && frame_bytes.ready) begin
			byte_s1  <= frame_bytes.data_byte;
			start_s1 <= frame_bytes.frame_start;
		end
	end

	// frame sequencing
	assign restart    = start_s1 || (pos_q > sfcc_pkg::POS_H_CRC);
	assign pos_eff    = restart ? sfcc_pkg::POS_T_MSB : pos_q;
	assign crc_in     = restart ? sfcc_pkg::CRC_INIT : crc_q;
	assign crc_step   = sfcc_pkg::crc8_byte(crc_in, byte_s1, crc_poly_q);
	assign final_byte = (pos_eff == sfcc_pkg::POS_H_CRC);
	assign advance    = valid_s1 && (!final_byte || !out_valid_q || readings.ready);
	assign err_now    = crc_en_q && (temp_bad_q || (crc_q != byte_s1));

	always_comb begin
		pos_next       = sfcc_pkg::POS_T_MSB;
		crc_next       = crc_step;
		temp_word_next = temp_word_q;
		temp_bad_next  = temp_bad_q;
		hum_hi_next    = hum_hi_q;
		hum_lo_next    = hum_lo_q;
		unique case (pos_eff)
			sfcc_pkg::POS_T_MSB: begin
				pos_next       = sfcc_pkg::POS_T_LSB;
				temp_word_next = {byte_s1, 8'h00};
			end
			sfcc_pkg::POS_T_LSB: begin
				pos_next       = sfcc_pkg::POS_T_CRC;
				temp_word_next = {temp_word_q[15:8], byte_s1};
			end
			sfcc_pkg::POS_T_CRC: begin
				pos_next      = sfcc_pkg::POS_H_MSB;
				temp_bad_next = (crc_q != byte_s1);
				crc_next      = sfcc_pkg::CRC_INIT;
			end
			sfcc_pkg::POS_H_MSB: begin
				pos_next    = sfcc_pkg::POS_H_LSB;
				hum_hi_next = byte_s1;
			end
			sfcc_pkg::POS_H_LSB: begin
				pos_next    = sfcc_pkg::POS_H_CRC;
				hum_lo_next = byte_s1;
			end
			sfcc_pkg::POS_H_CRC: begin
				pos_next = sfcc_pkg::POS_T_MSB;
				crc_next = sfcc_pkg::CRC_INIT;
			end
			default: begin
				pos_next = sfcc_pkg::POS_T_MSB;
				crc_next = sfcc_pkg::CRC_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= sfcc_pkg::POS_T_MSB;
			crc_q       <= sfcc_pkg::CRC_INIT;
			temp_word_q <= '0;
			temp_bad_q  <= 1'b0;
			hum_hi_q    <= '0;
		end else if (advance) begin
			pos_q       <= pos_next;
			crc_q       <= crc_next;
			temp_word_q <= temp_word_next;
			temp_bad_q  <= temp_bad_next;
			hum_hi_q    <= hum_hi_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hum_lo_q <= hum_lo_next;
		end
	end

	// conversion and reading register
	sfcc_convert u_convert (
		.temp_word            (temp_word_q),
		.hum_word             ({hum_hi_q, hum_lo_q}),
		.temperature_centideg (temp_conv),
		.humidity_centipct    (hum_conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_byte) begin
			out_valid_q <= 1'b1;
		end else if (readings.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_byte) begin
			temp_res_q <= temp_conv;
			hum_res_q  <= hum_conv;
			err_res_q  <= err_now;
		end
	end

	assign readings.valid                = out_valid_q;
	assign readings.temperature_centideg = temp_res_q;
	assign readings.humidity_centipct    = hum_res_q;
	assign readings.checksum_error       = err_res_q;

endmodule
`default_nettype wire

// ----- rtl/core/sfcc_convert.sv -----
`default_nettype none
module sfcc_convert (
	input  wire logic [15:0]     temp_word,
	input  wire logic [15:0]     hum_word,
	output sfcc_pkg::temp_t      temperature_centideg,
	output sfcc_pkg::hum_t       humidity_centipct
);

	logic [sfcc_pkg::TEMP_PROD_W-1:0] temp_prod;
	logic [sfcc_pkg::HUM_PROD_W-1:0]  hum_prod;
	logic [14:0]                      temp_scaled;

	assign temp_prod   = sfcc_pkg::TEMP_PROD_W'(temp_word)
		* sfcc_pkg::TEMP_PROD_W'(sfcc_pkg::TEMP_GAIN);
	assign hum_prod    = sfcc_pkg::HUM_PROD_W'(hum_word)
		* sfcc_pkg::HUM_PROD_W'(sfcc_pkg::HUM_GAIN);
	assign temp_scaled = temp_prod[sfcc_pkg::TEMP_PROD_W-1:sfcc_pkg::TEMP_SHIFT];

	assign temperature_centideg = sfcc_pkg::temp_t'(temp_scaled - sfcc_pkg::TEMP_OFFSET);
	assign humidity_centipct    = hum_prod[sfcc_pkg::HUM_PROD_W-1:sfcc_pkg::HUM_SHIFT];

endmodule
`default_nettype wire

// ----- rtl/core/sfcc_checker.sv -----
`default_nettype none
module sfcc_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire sfcc_pkg::temp_t out_temp,
	input wire sfcc_pkg::hum_t  out_hum,
	input wire logic            out_err
);

	// a held reading keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_hum)
			&& $stable(out_err))
		else $error("stalled reading changed");

	// a new reading follows a byte taken by the input handshake
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("reading without preceding byte");

	// humidity stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_hum <= 14'd9999)
		else $error("humidity out of range");

	// temperature stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_temp >= -15'sd4500) && (out_temp <= 15'sd12999))
		else $error("temperature out of range");

endmodule

bind sensor_frame_crc_and_conversion_top sfcc_checker u_sfcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame_bytes.valid),
	.in_ready  (frame_bytes.ready),
	.out_valid (readings.valid),
	.out_ready (readings.ready),
	.out_temp  (readings.temperature_centideg),
	.out_hum   (readings.humidity_centipct),
	.out_err   (readings.checksum_error)
);
`default_nettype wire
